// File: sv/dst_pkg.sv
`default_nettype none
package dst_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int FD_W     = 8;
  localparam int FDO_W    = 6;
  localparam int STATUS_W = 2;

  // input word: handle, fd, target_fd
  localparam int IN_W  = 32;
  // output word: status, fd_out, handle_out, acquire, release_res, released_handle, pad
  localparam int OUT_W = 48;

  localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUP       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUP2      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLOSE_ALL = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADF = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage
`default_nettype wire

// File: sv/dst_handle_mem.sv
`default_nettype none
module dst_handle_mem
  import dst_pkg::*;
#(
  parameter int ADDR_W = 4
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [HANDLE_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]   rd_addr_a,
  input  wire logic [ADDR_W-1:0]   rd_addr_b,
  output logic      [HANDLE_W-1:0] rd_data_a,
  output logic      [HANDLE_W-1:0] rd_data_b
);

  logic [HANDLE_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// File: sv/dst_free_find.sv
`default_nettype none
module dst_free_find
  import dst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [SLOTS-1:0] used,
  output logic                  found_r,
  output logic      [IDX_W-1:0] idx_r
);

  logic             found_nxt;
  logic [IDX_W-1:0] idx_nxt;

  // lowest empty slot wins: scan from the top down
  always_comb begin
    found_nxt = 1'b0;
    idx_nxt   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found_nxt = 1'b1;
        idx_nxt   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/descriptor_slot_table_top.sv
// Descriptor slot table with lowest-free allocation.
// Requests arrive on the in_ stream: in_tuser carries the request kind
// (allocate, close, get, dup, dup2, close all), in_tdata the handle and the
// descriptors. Results leave on the out_ stream; out_tlast marks the final
// word of a request.
// One request is in flight at a time. A single-result request is accepted in
// the idle state while its slots are addressed on the handle memory read
// ports; in the execution state the registered read data is used and the
// result is registered once the output register is free. The registered
// memory read and the read-modify-write of one entry set this sequence.
// Close all walks the slots one per cycle through the memory read port,
// emitting one release word per occupied slot and then a final word; an
// occupied slot waits while the output register is full.
// Reset empties every slot; handles are not cleared, an empty slot is never
// read. When out_tready is low the result word holds in the output register,
// the walk pauses on an occupied slot, and a request accepted meanwhile
// waits in execution until the output register is free.
`default_nettype none
module descriptor_slot_table_top
  import dst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // handle[15:0], fd[23:16], target_fd[31:24]
  input  wire logic [IN_W-1:0]   in_tdata,
  // kind[2:0]
  input  wire logic [KIND_W-1:0] in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // status[1:0], fd_out[7:2], handle_out[23:8], acquire[24], release_res[25],
  // released_handle[41:26], zero[47:42]
  output logic      [OUT_W-1:0]  out_tdata,
  output logic                   out_tlast
);

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = 1 << IW;
  localparam logic [FD_W-1:0] SLOTS_FD = FD_W'(SLOTS);
  localparam logic [IW-1:0]   LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FINAL
  } state_t;

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic [FD_W-1:0]     fd_r, fd_nxt;
  logic [FD_W-1:0]     tfd_r, tfd_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [DEPTH-1:0]    used_r, used_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [FDO_W-1:0]    o_fd_r, o_fd_nxt;
  logic [HANDLE_W-1:0] o_hout_r, o_hout_nxt;
  logic                o_acq_r, o_acq_nxt;
  logic                o_rel_r, o_rel_nxt;
  logic [HANDLE_W-1:0] o_rhnd_r, o_rhnd_nxt;
  logic                o_last_r, o_last_nxt;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic [IW-1:0]       rd_addr_a, rd_addr_b;
  logic [HANDLE_W-1:0] rd_data_a, rd_data_b;

  logic                free_found;
  logic [IW-1:0]       free_idx;

  logic [HANDLE_W-1:0] in_hnd;
  logic [FD_W-1:0]     in_fd, in_tfd;
  logic                in_acc;
  logic                can_emit;
  logic [IW-1:0]       fd_idx, tfd_idx;
  logic                fd_ok, tfd_ok;
  logic                walk_adv;

  assign in_hnd = in_tdata[15:0];
  assign in_fd  = in_tdata[23:16];
  assign in_tfd = in_tdata[31:24];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign can_emit  = !out_valid_r || out_tready;

  assign fd_idx  = fd_r[IW-1:0];
  assign tfd_idx = tfd_r[IW-1:0];
  assign fd_ok   = (fd_r < SLOTS_FD) && used_r[fd_idx];
  assign tfd_ok  = (tfd_r < SLOTS_FD);

  dst_handle_mem #(
    .ADDR_W(IW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  dst_free_find #(
    .SLOTS(SLOTS),
    .IDX_W(IW)
  ) u_free (
    .clk    (clk),
    .rst_n  (rst_n),
    .used   (used_r[SLOTS-1:0]),
    .found_r(free_found),
    .idx_r  (free_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    hnd_nxt       = hnd_r;
    fd_nxt        = fd_r;
    tfd_nxt       = tfd_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_fd_nxt      = o_fd_r;
    o_hout_nxt    = o_hout_r;
    o_acq_nxt     = o_acq_r;
    o_rel_nxt     = o_rel_r;
    o_rhnd_nxt    = o_rhnd_r;
    o_last_nxt    = o_last_r;
    wr_en         = 1'b0;
    wr_addr       = free_idx;
    wr_data       = hnd_r;
    rd_addr_a     = fd_idx;
    rd_addr_b     = tfd_idx;
    walk_adv      = 1'b0;

    case (state_r)
      S_IDLE: begin
        rd_addr_a = (in_tuser == KIND_CLOSE_ALL) ? '0 : in_fd[IW-1:0];
        rd_addr_b = in_tfd[IW-1:0];
        if (in_acc) begin
          kind_nxt  = in_tuser;
          hnd_nxt   = in_hnd;
          fd_nxt    = in_fd;
          tfd_nxt   = in_tfd;
          idx_nxt   = '0;
          state_nxt = (in_tuser == KIND_CLOSE_ALL) ? S_WALK : S_EXEC;
        end
      end

      S_EXEC: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_OK;
          o_fd_nxt      = '0;
          o_hout_nxt    = '0;
          o_acq_nxt     = 1'b0;
          o_rel_nxt     = 1'b0;
          o_rhnd_nxt    = '0;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
          case (kind_r)
            KIND_ALLOC: begin
              if (!free_found) begin
                o_status_nxt = ST_FULL;
              end else begin
                used_nxt[free_idx] = 1'b1;
                wr_en    = 1'b1;
                wr_addr  = free_idx;
                wr_data  = hnd_r;
                o_fd_nxt = FDO_W'(free_idx);
              end
            end
            KIND_CLOSE: begin
              if (!fd_ok) begin
                o_status_nxt = ST_BADF;
              end else begin
                used_nxt[fd_idx] = 1'b0;
                o_rel_nxt  = 1'b1;
                o_rhnd_nxt = rd_data_a;
              end
            end
            KIND_GET: begin
              if (!fd_ok) begin
                o_status_nxt = ST_BADF;
              end else begin
                o_hout_nxt = rd_data_a;
                o_acq_nxt  = 1'b1;
              end
            end
            KIND_DUP: begin
              if (!fd_ok) begin
                o_status_nxt = ST_BADF;
              end else if (!free_found) begin
                o_status_nxt = ST_FULL;
              end else begin
                used_nxt[free_idx] = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = free_idx;
                wr_data    = rd_data_a;
                o_fd_nxt   = FDO_W'(free_idx);
                o_hout_nxt = rd_data_a;
                o_acq_nxt  = 1'b1;
              end
            end
            KIND_DUP2: begin
              if (!fd_ok || !tfd_ok) begin
                o_status_nxt = ST_BADF;
              end else begin
                o_fd_nxt = FDO_W'(tfd_idx);
                // same handle already in the target: leave it alone
                if (!used_r[tfd_idx] || rd_data_b != rd_data_a) begin
                  used_nxt[tfd_idx] = 1'b1;
                  wr_en      = 1'b1;
                  wr_addr    = tfd_idx;
                  wr_data    = rd_data_a;
                  o_hout_nxt = rd_data_a;
                  o_acq_nxt  = 1'b1;
                  if (used_r[tfd_idx]) begin
                    o_rel_nxt  = 1'b1;
                    o_rhnd_nxt = rd_data_b;
                  end
                end
              end
            end
            default: begin
              o_status_nxt = ST_BADF;
            end
          endcase
        end
      end

      S_WALK: begin
        // read data always belongs to idx_r; skip empty slots without a word
        if (!used_r[idx_r]) begin
          walk_adv = 1'b1;
        end else if (can_emit) begin
          walk_adv         = 1'b1;
          used_nxt[idx_r]  = 1'b0;
          out_valid_nxt    = 1'b1;
          o_status_nxt     = ST_OK;
          o_fd_nxt         = '0;
          o_hout_nxt       = '0;
          o_acq_nxt        = 1'b0;
          o_rel_nxt        = 1'b1;
          o_rhnd_nxt       = rd_data_a;
          o_last_nxt       = 1'b0;
        end
        rd_addr_a = walk_adv ? idx_r + 1'b1 : idx_r;
        if (walk_adv) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FINAL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FINAL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_OK;
          o_fd_nxt      = '0;
          o_hout_nxt    = '0;
          o_acq_nxt     = 1'b0;
          o_rel_nxt     = 1'b0;
          o_rhnd_nxt    = '0;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    hnd_r      <= hnd_nxt;
    fd_r       <= fd_nxt;
    tfd_r      <= tfd_nxt;
    o_status_r <= o_status_nxt;
    o_fd_r     <= o_fd_nxt;
    o_hout_r   <= o_hout_nxt;
    o_acq_r    <= o_acq_nxt;
    o_rel_r    <= o_rel_nxt;
    o_rhnd_r   <= o_rhnd_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'd0, o_rhnd_r, o_rel_r, o_acq_r, o_hout_r, o_fd_r, o_status_r};

endmodule
`default_nettype wire

// File: dv/slot_table_checker.sv
`default_nettype none
module slot_table_checker
  import dst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  // handle[15:0], fd[23:16], target_fd[31:24]
  input  wire logic [IN_W-1:0]   in_tdata,
  // kind[2:0]
  input  wire logic [KIND_W-1:0] in_tuser,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  // status[1:0], fd_out[7:2], handle_out[23:8], acquire[24], release_res[25],
  // released_handle[41:26], zero[47:42]
  input  wire logic [OUT_W-1:0]  out_tdata,
  input  wire logic              out_tlast,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FDO_W-1:0]    fd_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                acquire;
    logic                release_res;
    logic [HANDLE_W-1:0] released_handle;
    logic                last;
  } slot_result_t;

  bit                  occupied  [SLOTS];
  logic [HANDLE_W-1:0] handle_of [SLOTS];
  slot_result_t        pending_results [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < 40)
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!occupied[i]) return i;
    return -1;
  endfunction

  task automatic predict_request(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] hnd,
                                 input logic [FD_W-1:0] fd, input logic [FD_W-1:0] tfd);
    slot_result_t r;
    slot_result_t rel;
    int s;
    bit src_ok;
    logic [HANDLE_W-1:0] h;
    r = '0;
    r.last = 1'b1;
    src_ok = (fd < SLOTS) ? occupied[fd] : 1'b0;
    case (kind)
      KIND_ALLOC: begin
        s = first_free();
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          occupied[s] = 1'b1;
          handle_of[s] = hnd;
          r.fd_out = FDO_W'(s);
        end
      end
      KIND_CLOSE: begin
        if (!src_ok) begin
          r.status = ST_BADF;
        end else begin
          occupied[fd] = 1'b0;
          r.release_res = 1'b1;
          r.released_handle = handle_of[fd];
        end
      end
      KIND_GET: begin
        if (!src_ok) begin
          r.status = ST_BADF;
        end else begin
          r.handle_out = handle_of[fd];
          r.acquire = 1'b1;
        end
      end
      KIND_DUP: begin
        s = first_free();
        if (!src_ok) begin
          r.status = ST_BADF;
        end else if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          occupied[s] = 1'b1;
          handle_of[s] = handle_of[fd];
          r.fd_out = FDO_W'(s);
          r.handle_out = handle_of[fd];
          r.acquire = 1'b1;
        end
      end
      KIND_DUP2: begin
        if (!src_ok || tfd >= SLOTS) begin
          r.status = ST_BADF;
        end else begin
          h = handle_of[fd];
          r.fd_out = tfd[FDO_W-1:0];
          // same handle already in the target: no reference moves
          if (!(occupied[tfd] && handle_of[tfd] == h)) begin
            if (occupied[tfd]) begin
              r.release_res = 1'b1;
              r.released_handle = handle_of[tfd];
            end
            occupied[tfd] = 1'b1;
            handle_of[tfd] = h;
            r.handle_out = h;
            r.acquire = 1'b1;
          end
        end
      end
      KIND_CLOSE_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (occupied[i]) begin
            occupied[i] = 1'b0;
            rel = '0;
            rel.release_res = 1'b1;
            rel.released_handle = handle_of[i];
            pending_results.push_back(rel);
          end
        end
      end
      default: r.status = ST_BADF;
    endcase
    pending_results.push_back(r);
  endtask

  task automatic check_word();
    slot_result_t want;
    if (pending_results.size() == 0) begin
      report("word with no request pending", 64'(out_tdata), '0);
      return;
    end
    want = pending_results.pop_front();
    if (out_tdata[1:0] !== want.status)
      report("status", 64'(out_tdata[1:0]), 64'(want.status));
    if (out_tdata[7:2] !== want.fd_out)
      report("fd_out", 64'(out_tdata[7:2]), 64'(want.fd_out));
    if (out_tdata[23:8] !== want.handle_out)
      report("handle_out", 64'(out_tdata[23:8]), 64'(want.handle_out));
    if (out_tdata[24] !== want.acquire)
      report("acquire", 64'(out_tdata[24]), 64'(want.acquire));
    if (out_tdata[25] !== want.release_res)
      report("release_res", 64'(out_tdata[25]), 64'(want.release_res));
    if (out_tdata[41:26] !== want.released_handle)
      report("released_handle", 64'(out_tdata[41:26]), 64'(want.released_handle));
    if (out_tdata[47:42] !== '0)
      report("pad bits", 64'(out_tdata[47:42]), '0);
    if (out_tlast !== want.last)
      report("tlast", 64'(out_tlast), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      // retire the older request's word before queueing a new request
      if (out_tvalid && out_tready) check_word();
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[15:0], in_tdata[23:16], in_tdata[31:24]);
    end
    outstanding = pending_results.size();
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
  import dst_pkg::*;

  localparam int ITEMS = 320;
  // kind codes the block does not define
  localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;
  localparam logic [FD_W-1:0]   FD_MAX      = 8'hFF;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata   = '0;
  logic [KIND_W-1:0]   in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;
  int                  mismatches;
  int                  outstanding;
  int                  sent = 0;
  bit                  tight = 1'b0;
  logic [HANDLE_W-1:0] handle_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

  descriptor_slot_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  slot_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("FAIL descriptor_slot_table_top");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 9) < 4) return handle_pool[$urandom_range(0, 3)];
    return HANDLE_W'($urandom);
  endfunction

  function automatic logic [FD_W-1:0] pick_fd();
    if ($urandom_range(0, 99) < 92) return FD_W'($urandom_range(0, SLOTS_DEF - 1));
    return FD_W'($urandom_range(0, 255));
  endfunction

  // hold the word until taken; keep valid high when no gap follows
  task automatic offer(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] hnd,
                       input logic [FD_W-1:0] fd, input logic [FD_W-1:0] tfd);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {tfd, fd, hnd};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request(input bit filling, input bit noisy);
    logic [KIND_W-1:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (noisy) begin
      kind = KIND_W'($urandom_range(KIND_ALLOC, KIND_RSVD_B));
      offer(kind, HANDLE_W'($urandom), FD_W'($urandom_range(0, 255)),
            FD_W'($urandom_range(0, 255)));
    end else begin
      if (filling)      kind = (r < 80) ? KIND_ALLOC : KIND_DUP;
      else if (r < 24)  kind = KIND_ALLOC;
      else if (r < 40)  kind = KIND_CLOSE;
      else if (r < 54)  kind = KIND_GET;
      else if (r < 70)  kind = KIND_DUP;
      else if (r < 94)  kind = KIND_DUP2;
      else              kind = KIND_CLOSE_ALL;
      offer(kind, pick_handle(), pick_fd(), pick_fd());
    end
  endtask

  initial begin : drain
    int span;
    int r;
    bit held_long;
    held_long = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held_long && sent >= 120) begin
        // long hold while requests keep coming: input must stall
        held_long = 1'b1;
        out_tready <= 1'b0;
        span = 400;
      end else if (r < 50) begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(10, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    int sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(KIND_CLOSE_ALL, 16'h0000, 8'd0, 8'd0);      // empty table: final word only
    offer(KIND_GET, 16'h0000, 8'd0, 8'd0);            // empty slot
    offer(KIND_CLOSE, 16'h0000, FD_MAX, 8'd0);        // descriptor out of range
    offer(KIND_DUP, 16'h0000, 8'd3, 8'd0);            // empty source
    offer(KIND_ALLOC, 16'hFFFF, 8'd0, 8'd0);
    offer(KIND_ALLOC, 16'h0000, 8'd0, 8'd0);
    offer(KIND_GET, 16'h0000, 8'd0, 8'd0);
    offer(KIND_GET, 16'h0000, 8'(SLOTS_DEF), 8'd0);
    offer(KIND_DUP, 16'h0000, 8'd0, 8'd0);
    offer(KIND_DUP2, 16'h0000, 8'd0, 8'd2);           // target holds the same handle
    offer(KIND_DUP2, 16'h0000, 8'd1, 8'd1);           // onto itself
    offer(KIND_DUP2, 16'h0000, 8'd1, 8'd0);           // replace a different handle
    offer(KIND_DUP2, 16'h0000, 8'd0, 8'(SLOTS_DEF - 1)); // empty target
    offer(KIND_DUP2, 16'h0000, 8'd0, 8'(SLOTS_DEF));  // target out of range
    offer(KIND_DUP2, 16'h0000, FD_MAX, 8'd0);
    offer(KIND_RSVD_A, 16'hFFFF, FD_MAX, FD_MAX);
    offer(KIND_RSVD_B, 16'hFFFF, FD_MAX, FD_MAX);
    offer(KIND_CLOSE, 16'h0000, 8'd2, 8'd0);
    offer(KIND_ALLOC, 16'hA5C3, 8'd0, 8'd0);
    offer(KIND_CLOSE_ALL, 16'h0000, 8'd0, 8'd0);

    while (sent < ITEMS) begin
      sel = $urandom_range(0, 9);
      tight = ($urandom_range(0, 3) == 0);
      if (sel < 2) begin
        // fill past capacity, then hit the full table
        repeat ($urandom_range(17, 21)) random_request(1'b1, 1'b0);
        repeat (3) random_request(1'b0, 1'b0);
      end else if (sel == 2) begin
        repeat ($urandom_range(2, 6)) random_request(1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(6, 18)) random_request(1'b0, 1'b0);
      end
    end
    tight = 1'b0;
    in_tvalid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (SLOTS_DEF + 8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS descriptor_slot_table_top");
    end else begin
      $display("FAIL descriptor_slot_table_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
